// File: rtl/gain_scaled_iir_band_equalizer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the band equalizer
// Shared concurrent-assertion shorthands clocked on clk, reset by arst_n.
// ---------------------------------------------------------------------------
`ifndef GAIN_SCALED_IIR_BAND_EQUALIZER_MACROS_SVH
`define GAIN_SCALED_IIR_BAND_EQUALIZER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define GSIE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("equalizer assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define GSIE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("equalizer assertion failed");

`endif

// File: rtl/gsie_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Band equalizer package
// Types, register codes, reset values and fixed tables of the equalizer.
// ---------------------------------------------------------------------------
package gsie_pkg;

	// Configuration port address width and register reset values.
	localparam int PADDR_W = 4;
	localparam logic [5:0]  ACTIVE_BANDS_RST = 6'd26;
	localparam logic [15:0] GAIN_DECAY_RST   = 16'd52429;
	localparam logic [15:0] OUTPUT_SCALE_RST = 16'd39322;

	// Item kinds as they arrive on the input channel.
	typedef enum logic [1:0] {
		KIND_SAMPLE  = 2'd0,
		KIND_LOAD_FF = 2'd1,
		KIND_LOAD_FB = 2'd2,
		KIND_GAIN    = 2'd3
	} kind_t;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_ACTIVE_BANDS = 2'd0,
		REG_GAIN_DECAY   = 2'd1,
		REG_OUTPUT_SCALE = 2'd2
	} reg_idx_t;

	// Operations after classification by the front end.
	typedef enum logic [2:0] {
		OP_SAMPLE,
		OP_LOAD_FF,
		OP_LOAD_FB,
		OP_GAIN,
		OP_DROP
	} op_t;

	// Command queued between front and back.
	typedef struct packed {
		op_t                op;
		logic signed [15:0] sample;
		logic [4:0]         band;
		logic [3:0]         tap;
		logic signed [31:0] coeff;
		logic signed [7:0]  raw_gain;
	} cmd_t;

	// Configuration register set.
	typedef struct packed {
		logic [5:0]  active_bands;
		logic [15:0] gain_decay;
		logic [15:0] output_scale;
	} cfg_t;

	// Back-end sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAIN_MUL,
		ST_GAIN_WR,
		ST_BAND_RD,
		ST_TAP_M1,
		ST_TAP_M2,
		ST_TAP_M3,
		ST_BAND_FIN,
		ST_BAND_WB,
		ST_OUT_MUL,
		ST_OUT_WR
	} bk_state_t;

	// Gain magnitude table: round(m * 32768 / 127), halves away from zero.
	typedef logic [16:0] glut_t [129];

	function automatic glut_t gain_lut_build();
		glut_t t;
		for (int m = 0; m <= 128; m++) begin
			t[m] = 17'((m * 65536 + 127) / 254);
		end
		return t;
	endfunction

	localparam glut_t GAIN_LUT = gain_lut_build();

	// Saturate a 64-bit signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd2147483647;
		lo = -64'sd2147483648;
		if (v > hi) begin
			return 32'sh7FFFFFFF;
		end
		if (v < lo) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

// File: rtl/gsie_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Band equalizer channels
// Valid/ready channels for input items and output results.
// ---------------------------------------------------------------------------

// Input item channel.
interface gsie_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [15:0] sample;
	logic [4:0]         band;
	logic [3:0]         tap;
	logic signed [31:0] coeff_value;
	logic signed [7:0]  raw_gain;

	modport source(output valid, kind, sample, band, tap, coeff_value, raw_gain,
		input ready);
	modport sink(input valid, kind, sample, band, tap, coeff_value, raw_gain,
		output ready);
endinterface

// Result channel.
interface gsie_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] filtered_sample;
	logic               clipped;

	modport source(output valid, filtered_sample, clipped, input ready);
	modport sink(input valid, filtered_sample, clipped, output ready);
endinterface

// File: rtl/gsie_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
module gsie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 160,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Storage array and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/gsie_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Band equalizer front end
// Accepts input beats, classifies them and queues commands for the back end.
// ---------------------------------------------------------------------------
module gsie_front #(
	parameter int MAX_BANDS    = 32,
	parameter int FILTER_ORDER = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	gsie_item_if.sink     items,
	output gsie_pkg::cmd_t cmd,
	output logic          cmd_valid,
	input  logic          cmd_pop
);
	import gsie_pkg::*;

	localparam int NTAPS = 2 * FILTER_ORDER + 1;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	logic       band_ok;
	logic       tap_ok;
	cmd_t       cmd_new;

	// Classify the incoming beat; out-of-range loads and updates are dropped.
	always_comb begin
		band_ok          = int'(items.band) < MAX_BANDS;
		tap_ok           = int'(items.tap) < NTAPS;
		cmd_new.sample   = items.sample;
		cmd_new.band     = items.band;
		cmd_new.tap      = items.tap;
		cmd_new.coeff    = items.coeff_value;
		cmd_new.raw_gain = items.raw_gain;
		case (items.kind)
			KIND_SAMPLE:  cmd_new.op = OP_SAMPLE;
			KIND_LOAD_FF: cmd_new.op = (band_ok && tap_ok) ? OP_LOAD_FF : OP_DROP;
			KIND_LOAD_FB: cmd_new.op = (band_ok && tap_ok) ? OP_LOAD_FB : OP_DROP;
			KIND_GAIN:    cmd_new.op = band_ok ? OP_GAIN : OP_DROP;
			default:      cmd_new.op = OP_DROP;
		endcase
	end

	assign items.ready = (cnt_q != 2'd2);
	assign push        = items.valid && items.ready;
	assign cmd_valid   = (cnt_q != 2'd0);
	assign pop         = cmd_pop && cmd_valid;
	assign cmd         = slot_q[rd_ptr_q];

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_new;
		end
	end

endmodule

// File: rtl/gsie_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Band equalizer back end
// Executes queued commands: coefficient loads, gain updates and the per-sample
// filter bank evaluation, with gain and tap products on one shared 32x32 multiplier.
// ---------------------------------------------------------------------------
module gsie_back #(
	parameter int MAX_BANDS    = 32,
	parameter int FILTER_ORDER = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  gsie_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	input  gsie_pkg::cfg_t cfg,
	gsie_result_if.source  results
);
	import gsie_pkg::*;

	localparam int NTAPS  = 2 * FILTER_ORDER + 1;
	localparam int NHIST  = 2 * FILTER_ORDER;
	localparam int CDEPTH = MAX_BANDS * NTAPS;
	localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
	localparam int BIW    = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
	localparam int NBW    = $clog2(MAX_BANDS + 1);
	localparam int TW     = $clog2(NTAPS);
	localparam int HIW    = $clog2(NHIST);
	localparam int HW     = NHIST * 32;
	localparam int TOTW   = 32 + NBW;
	localparam int OW     = TOTW + 17;
	localparam logic signed [OW-1:0] OMAX = 32767;
	localparam logic signed [OW-1:0] OMIN = -32768;
	localparam logic signed [OW-1:0] ORND = 1 << 24;

	bk_state_t state_q, nxt;

	// Sequencer counters and control.
	logic [NBW-1:0]     n_q;
	logic [NBW-1:0]     nb_q;
	logic [NBW-1:0]     nbv;
	logic [TW-1:0]      c_q;
	logic               pend_q;
	logic               hv_q;
	logic [MAX_BANDS-1:0] hvld_q;

	// Datapath registers.
	logic signed [15:0] x_q;
	logic signed [15:0] hx_q [NHIST];
	logic signed [15:0] gain_q [MAX_BANDS];
	logic signed [63:0] acc_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] fb_q;
	logic [HW-1:0]      yrow_q;
	logic signed [TOTW-1:0] total_q;
	logic [BIW-1:0]     gb_q;
	logic signed [7:0]  graw_q;
	logic signed [15:0] gnew_q;
	logic signed [OW-1:0] oprod_q;
	logic               ovalid_q;
	logic signed [15:0] odata_q;
	logic               oclip_q;

	// Memory ports.
	logic               ff_we;
	logic               fb_we;
	logic               coef_re;
	logic [CAW-1:0]     coef_waddr;
	logic [CAW-1:0]     coef_raddr;
	logic [31:0]        ff_rdata;
	logic [31:0]        fb_rdata;
	logic               hist_re;
	logic               hist_we;
	logic [HW-1:0]      hist_rdata;
	logic [HW-1:0]      hist_wdata;
	int                 rd_tap;

	// Combinational datapath values.
	logic [BIW-1:0]     band_idx;
	logic [BIW-1:0]     gidx;
	logic signed [15:0] gsel;
	logic [HIW-1:0]     hidx;
	logic signed [15:0] xv;
	logic signed [31:0] yprev;
	logic signed [63:0] beff_t;
	logic signed [31:0] beff;
	logic signed [31:0] ma;
	logic signed [31:0] mb;
	logic signed [63:0] mp;
	logic [7:0]         gmag;
	logic [16:0]        glut;
	logic signed [17:0] gfull;
	logic signed [15:0] gsat;
	logic signed [63:0] dec_t;
	logic signed [15:0] gdec;
	logic signed [63:0] y_t;
	logic signed [31:0] ynew;
	logic signed [OW-1:0] o_t;
	logic               out_free;

	assign band_idx = n_q[BIW-1:0];
	assign nbv = (int'(cfg.active_bands) > MAX_BANDS) ? NBW'(MAX_BANDS)
		: NBW'(cfg.active_bands);

	// Gain of the band being updated or filtered.
	assign gidx = (state_q == ST_GAIN_MUL) ? gb_q : band_idx;
	assign gsel = gain_q[gidx];

	// Input and output history taps for the current tap index.
	assign hidx  = (c_q == '0) ? '0 : HIW'(c_q - TW'(1));
	assign xv    = (c_q == '0) ? x_q : hx_q[hidx];
	assign yprev = yrow_q[hidx*32 +: 32];

	// Effective feed-forward coefficient from the b*gain product.
	assign beff_t = (prod_q + 64'sd16384) >>> 15;
	assign beff   = sat32(beff_t);

	// New gain from the q0.7 value.
	always_comb begin
		gmag  = graw_q[7] ? 8'(-int'(graw_q)) : 8'(graw_q);
		glut  = GAIN_LUT[gmag];
		gfull = graw_q[7] ? -$signed({1'b0, glut}) : $signed({1'b0, glut});
		if (gfull > 18'sd32767) begin
			gsat = 16'sh7FFF;
		end else if (gfull < -18'sd32768) begin
			gsat = 16'sh8000;
		end else begin
			gsat = gfull[15:0];
		end
	end

	assign dec_t = (prod_q + 64'sd32768) >>> 16;
	assign gdec  = dec_t[15:0];

	// Band output and final output rounding.
	assign y_t  = (acc_q + 64'sd262144) >>> 19;
	assign ynew = sat32(y_t);
	assign o_t  = (oprod_q + ORND) >>> 25;
	assign hist_wdata = {yrow_q[HW-33:0], ynew};

	// Shared multiplier operand selection.
	always_comb begin
		case (state_q)
			ST_GAIN_MUL: begin
				ma = 32'(gsel);
				mb = $signed({16'b0, cfg.gain_decay});
			end
			ST_TAP_M1: begin
				ma = $signed(ff_rdata);
				mb = 32'(gsel);
			end
			ST_TAP_M2: begin
				ma = beff;
				mb = 32'(xv);
			end
			ST_TAP_M3: begin
				ma = fb_q;
				mb = yprev;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign mp = ma * mb;

	assign coef_waddr = CAW'(int'(cmd.band) * NTAPS + int'(cmd.tap));
	assign coef_raddr = CAW'(int'(band_idx) * NTAPS + rd_tap);
	assign out_free   = !ovalid_q || results.ready;

	// Next state and strobes.
	always_comb begin
		nxt     = state_q;
		cmd_pop = 1'b0;
		ff_we   = 1'b0;
		fb_we   = 1'b0;
		coef_re = 1'b0;
		hist_re = 1'b0;
		hist_we = 1'b0;
		rd_tap  = 0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						OP_LOAD_FF: ff_we = 1'b1;
						OP_LOAD_FB: fb_we = 1'b1;
						OP_GAIN:    nxt = ST_GAIN_MUL;
						OP_SAMPLE:  nxt = (nbv == '0) ? ST_OUT_MUL : ST_BAND_RD;
						default:    nxt = ST_IDLE;
					endcase
				end
			end
			ST_GAIN_MUL: nxt = ST_GAIN_WR;
			ST_GAIN_WR:  nxt = ST_IDLE;
			ST_BAND_RD: begin
				coef_re = 1'b1;
				hist_re = 1'b1;
				rd_tap  = 0;
				nxt     = ST_TAP_M1;
			end
			ST_TAP_M1: nxt = ST_TAP_M2;
			ST_TAP_M2: begin
				rd_tap = int'(c_q) + 1;
				if (int'(c_q) != NTAPS - 1) begin
					coef_re = 1'b1;
				end
				nxt = ST_TAP_M3;
			end
			ST_TAP_M3: begin
				nxt = (int'(c_q) == NTAPS - 1) ? ST_BAND_FIN : ST_TAP_M1;
			end
			ST_BAND_FIN: nxt = ST_BAND_WB;
			ST_BAND_WB: begin
				hist_we = 1'b1;
				nxt = (n_q + NBW'(1) == nb_q) ? ST_OUT_MUL : ST_BAND_RD;
			end
			ST_OUT_MUL: nxt = ST_OUT_WR;
			ST_OUT_WR: begin
				if (out_free) begin
					nxt = ST_IDLE;
				end
			end
			default: nxt = ST_IDLE;
		endcase
	end

	// Control state, gains, histories and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			n_q      <= '0;
			hvld_q   <= '0;
			ovalid_q <= 1'b0;
			for (int k = 0; k < MAX_BANDS; k++) begin
				gain_q[k] <= '0;
			end
			for (int k = 0; k < NHIST; k++) begin
				hx_q[k] <= '0;
			end
		end else begin
			state_q <= nxt;
			if (state_q == ST_IDLE && cmd_valid && cmd.op == OP_SAMPLE) begin
				n_q <= '0;
			end
			if (state_q == ST_GAIN_WR) begin
				gain_q[gb_q] <= (gdec > gnew_q) ? gdec : gnew_q;
			end
			if (state_q == ST_BAND_WB) begin
				hvld_q[band_idx] <= 1'b1;
				n_q <= n_q + NBW'(1);
			end
			if (state_q == ST_OUT_WR && out_free) begin
				ovalid_q <= 1'b1;
				for (int k = NHIST - 1; k > 0; k--) begin
					hx_q[k] <= hx_q[k-1];
				end
				hx_q[0] <= x_q;
			end else if (results.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Arithmetic registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				gb_q    <= BIW'(cmd.band);
				graw_q  <= cmd.raw_gain;
				x_q     <= cmd.sample;
				nb_q    <= nbv;
				total_q <= '0;
			end
			ST_GAIN_MUL: begin
				prod_q <= mp;
				gnew_q <= gsat;
			end
			ST_BAND_RD: begin
				c_q    <= '0;
				acc_q  <= '0;
				pend_q <= 1'b0;
				hv_q   <= hvld_q[band_idx];
			end
			ST_TAP_M1: begin
				prod_q <= mp;
				fb_q   <= $signed(fb_rdata);
				if (c_q == '0) begin
					yrow_q <= hv_q ? hist_rdata : '0;
				end
				if (pend_q) begin
					acc_q <= acc_q - (prod_q >>> 9);
				end
			end
			ST_TAP_M2: prod_q <= mp;
			ST_TAP_M3: begin
				acc_q  <= acc_q + prod_q;
				c_q    <= c_q + TW'(1);
				pend_q <= (c_q != '0);
				if (c_q != '0) begin
					prod_q <= mp;
				end
			end
			ST_BAND_FIN: begin
				if (pend_q) begin
					acc_q <= acc_q - (prod_q >>> 9);
				end
			end
			ST_BAND_WB: total_q <= total_q + TOTW'(ynew);
			ST_OUT_MUL: oprod_q <= total_q * $signed({1'b0, cfg.output_scale});
			ST_OUT_WR: begin
				if (out_free) begin
					if (o_t > OMAX) begin
						odata_q <= 16'sh7FFF;
						oclip_q <= 1'b1;
					end else if (o_t < OMIN) begin
						odata_q <= 16'sh8000;
						oclip_q <= 1'b1;
					end else begin
						odata_q <= o_t[15:0];
						oclip_q <= 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Feed-forward and feedback coefficient memories.
	gsie_ram #(.WIDTH(32), .DEPTH(CDEPTH)) u_ff_ram (
		.clk   (clk),
		.we    (ff_we),
		.waddr (coef_waddr),
		.wdata (cmd.coeff),
		.re    (coef_re),
		.raddr (coef_raddr),
		.rdata (ff_rdata)
	);

	gsie_ram #(.WIDTH(32), .DEPTH(CDEPTH)) u_fb_ram (
		.clk   (clk),
		.we    (fb_we),
		.waddr (coef_waddr),
		.wdata (cmd.coeff),
		.re    (coef_re),
		.raddr (coef_raddr),
		.rdata (fb_rdata)
	);

	// Band output history, one row per band.
	gsie_ram #(.WIDTH(HW), .DEPTH(MAX_BANDS)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (band_idx),
		.wdata (hist_wdata),
		.re    (hist_re),
		.raddr (band_idx),
		.rdata (hist_rdata)
	);

	assign results.valid           = ovalid_q;
	assign results.filtered_sample = odata_q;
	assign results.clipped         = oclip_q;

endmodule

// File: rtl/gain_scaled_iir_band_equalizer.sv
`timescale 1ns / 1ps
// Samples run through the shared multiply-accumulate sequencer band by band,
// each tap in the states TAP_M1, TAP_M2 and TAP_M3.
// Coefficient loads are written from the idle state, gain updates pass GAIN_MUL and GAIN_WR;
// a two-entry queue takes beats meanwhile.
// Reset clears configuration to defaults, gains, sample history and band history
// valid bits at once; coefficient memories stay undefined until written.
// ---------------------------------------------------------------------------
// Gain-scaled IIR band equalizer
// Top level: configuration registers, front end queue and back end sequencer.
// ---------------------------------------------------------------------------
module gain_scaled_iir_band_equalizer #(
	parameter int MAX_BANDS    = 32,
	parameter int FILTER_ORDER = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	gsie_item_if.sink                   items,
	gsie_result_if.source               results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gsie_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import gsie_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_bands <= ACTIVE_BANDS_RST;
			cfg_q.gain_decay   <= GAIN_DECAY_RST;
			cfg_q.output_scale <= OUTPUT_SCALE_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_ACTIVE_BANDS: cfg_q.active_bands <= pwdata[5:0];
				REG_GAIN_DECAY:   cfg_q.gain_decay   <= pwdata[15:0];
				REG_OUTPUT_SCALE: cfg_q.output_scale <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[3:2])
			REG_ACTIVE_BANDS: prdata = 32'(cfg_q.active_bands);
			REG_GAIN_DECAY:   prdata = 32'(cfg_q.gain_decay);
			REG_OUTPUT_SCALE: prdata = 32'(cfg_q.output_scale);
			default:          prdata = '0;
		endcase
	end

	gsie_front #(.MAX_BANDS(MAX_BANDS), .FILTER_ORDER(FILTER_ORDER)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	gsie_back #(.MAX_BANDS(MAX_BANDS), .FILTER_ORDER(FILTER_ORDER)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cfg       (cfg_q),
		.results   (results)
	);

endmodule

// File: rtl/gsie_chk.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Band equalizer port checker
// Watches the top-level ports for result handshake rules and register read-back.
// ---------------------------------------------------------------------------
`include "gain_scaled_iir_band_equalizer_macros.svh"

module gsie_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  in_kind,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_data,
	input logic        out_clip,
	input logic        psel,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic [31:0] prdata
);
	import gsie_pkg::*;

	logic [3:0] pend_q;
	logic       samp_acc;
	logic       res_acc;

	assign samp_acc = in_valid && in_ready && (in_kind == KIND_SAMPLE);
	assign res_acc  = out_valid && out_ready;

	// Samples accepted but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 4'(samp_acc) - 4'(res_acc);
		end
	end

	`GSIE_ASSERT_NEXT(a_out_valid_hold, out_valid && !out_ready, out_valid)
	`GSIE_ASSERT_NEXT(a_out_data_hold, out_valid && !out_ready, $stable(out_data) && $stable(out_clip))
	`GSIE_ASSERT(a_no_extra_result, out_valid |-> (pend_q != 4'd0))
	`GSIE_ASSERT(a_bands_readback, (psel && !pwrite && paddr[3:2] == REG_ACTIVE_BANDS) |-> (prdata[31:6] == 26'd0))

endmodule

bind gain_scaled_iir_band_equalizer gsie_chk u_gsie_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.in_kind   (items.kind),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.filtered_sample),
	.out_clip  (results.clipped),
	.psel      (psel),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.prdata    (prdata)
);

// File: tb/tb_gain_scaled_iir_band_equalizer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Band equalizer testbench
// Loads every coefficient that a sample reads in every band, then drives directed and random
// samples, coefficient loads and gain updates through the item channel.
// A bit-exact predictor of the filter bank computes each output sample,
// and a monitor checks every result beat against it. The run steps through
// several register settings, under three idling patterns on both sides.
// ---------------------------------------------------------------------------
module tb_gain_scaled_iir_band_equalizer;
	import gsie_pkg::*;

	localparam int NBANDS = 32;
	localparam int NTAPS  = 5;
	localparam int NHIST  = 4;
	localparam int SETTLE = 700;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		kind_t              kind;
		logic signed [15:0] sample;
		logic [4:0]         band;
		logic [3:0]         tap;
		logic signed [31:0] coeff;
		logic signed [7:0]  raw_gain;
	} eq_item_t;

	typedef struct {
		logic signed [15:0] value;
		logic               clip;
	} eq_out_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	gsie_item_if   item_ch();
	gsie_result_if res_ch();

	gain_scaled_iir_band_equalizer dut (
		.clk(clk), .arst_n(arst_n), .items(item_ch), .results(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor state: coefficients, gains, histories and registers.
	logic signed [31:0] ff_taps [NBANDS][NTAPS];
	logic signed [31:0] fb_taps [NBANDS][NTAPS];
	logic signed [15:0] gain_model [NBANDS];
	logic signed [15:0] x_hist [NHIST];
	logic signed [31:0] y_hist [NBANDS][NHIST];
	logic [5:0]  cfg_bands;
	logic [15:0] cfg_decay;
	logic [15:0] cfg_scale;

	eq_item_t pending_items[$];
	eq_out_t  expected_outputs[$];
	eq_item_t drive_item;
	int snd_idle;
	int rcv_idle;
	int errors;
	int stall_cycles;
	int samples_checked;
	int loads_seen;
	int gains_seen;

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Apply one accepted item to the predictor; samples queue an output.
	task automatic equalize(input eq_item_t it);
		longint acc, y, beff, xv, total, o, r, g, d, mag, rg;
		int nb;
		eq_out_t res;
		case (it.kind)
			KIND_LOAD_FF: begin
				loads_seen++;
				if (it.tap < NTAPS) ff_taps[it.band][it.tap] = it.coeff;
			end
			KIND_LOAD_FB: begin
				loads_seen++;
				if (it.tap < NTAPS) fb_taps[it.band][it.tap] = it.coeff;
			end
			KIND_GAIN: begin
				gains_seen++;
				rg = longint'(it.raw_gain);
				mag = rg < 0 ? -rg : rg;
				g = (mag * 65536 + 127) / 254;
				if (rg < 0) g = -g;
				g = clamp(g, -32768, 32767);
				d = (longint'(gain_model[it.band]) * longint'(cfg_decay) + 32768) >>> 16;
				gain_model[it.band] = 16'(d > g ? d : g);
			end
			default: begin
				nb = cfg_bands > NBANDS ? NBANDS : int'(cfg_bands);
				total = 0;
				for (int n = 0; n < nb; n++) begin
					acc = 0;
					for (int c = 0; c < NTAPS; c++) begin
						xv = (c == 0) ? longint'(it.sample) : longint'(x_hist[c - 1]);
						beff = (longint'(ff_taps[n][c]) * longint'(gain_model[n]) + 16384) >>> 15;
						beff = clamp(beff, -64'sd2147483648, 64'sd2147483647);
						acc += beff * xv;
					end
					for (int c = 1; c < NTAPS; c++) begin
						acc -= (longint'(fb_taps[n][c]) * longint'(y_hist[n][c - 1])) >>> 9;
					end
					y = clamp((acc + 262144) >>> 19, -64'sd2147483648, 64'sd2147483647);
					for (int c = NHIST - 1; c > 0; c--) y_hist[n][c] = y_hist[n][c - 1];
					y_hist[n][0] = 32'(y);
					total += y;
				end
				for (int c = NHIST - 1; c > 0; c--) x_hist[c] = x_hist[c - 1];
				x_hist[0] = it.sample;
				o = (total * longint'(cfg_scale) + 16777216) >>> 25;
				r = clamp(o, -32768, 32767);
				res.value = 16'(r);
				res.clip = (r != o);
				expected_outputs.push_back(res);
			end
		endcase
	endtask

	// Clock.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Item driver: one beat per handshake, with random sender gaps.
	always @(posedge clk) begin
		if (arst_n && (!item_ch.valid || item_ch.ready)) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= snd_idle) begin
				drive_item = pending_items.pop_front();
				item_ch.kind        <= drive_item.kind;
				item_ch.sample      <= drive_item.sample;
				item_ch.band        <= drive_item.band;
				item_ch.tap         <= drive_item.tap;
				item_ch.coeff_value <= drive_item.coeff;
				item_ch.raw_gain    <= drive_item.raw_gain;
				item_ch.valid       <= 1'b1;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver stalls at random.
	always @(posedge clk) begin
		res_ch.ready <= arst_n && ($urandom_range(99) >= rcv_idle);
	end

	// Monitor: feed accepted items to the predictor and check result beats.
	always @(posedge clk) begin
		eq_item_t seen;
		eq_out_t want;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				seen.kind     = kind_t'(item_ch.kind);
				seen.sample   = item_ch.sample;
				seen.band     = item_ch.band;
				seen.tap      = item_ch.tap;
				seen.coeff    = item_ch.coeff_value;
				seen.raw_gain = item_ch.raw_gain;
				equalize(seen);
			end
			if (res_ch.valid && res_ch.ready) begin
				if (expected_outputs.size() == 0) begin
					$error("unexpected result beat: filtered_sample %0d", res_ch.filtered_sample);
					errors++;
				end else begin
					want = expected_outputs.pop_front();
					samples_checked++;
					if (res_ch.filtered_sample !== want.value) begin
						$error("filtered_sample expected %0d actual %0d",
							want.value, res_ch.filtered_sample);
						errors++;
					end
					if (res_ch.clipped !== want.clip) begin
						$error("clipped expected %0d actual %0d", want.clip, res_ch.clipped);
						errors++;
					end
				end
			end
			// Watchdog over cycles with work pending but no beat moving.
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(pending_items.size() == 0 && expected_outputs.size() == 0 && !item_ch.valid)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("gain_scaled_iir_band_equalizer: mismatch");
					$finish;
				end
			end
		end
	end

	function automatic eq_item_t noise_item(input kind_t k);
		eq_item_t it;
		it.kind     = k;
		it.sample   = 16'($urandom);
		it.band     = 5'($urandom);
		it.tap      = 4'($urandom_range(NTAPS - 1));
		it.coeff    = 32'($urandom);
		it.raw_gain = 8'($urandom);
		return it;
	endfunction

	task automatic push_sample(input logic signed [15:0] s);
		eq_item_t it;
		it = noise_item(KIND_SAMPLE);
		it.sample = s;
		pending_items.push_back(it);
	endtask

	task automatic push_load(input kind_t k, input int b, input int t,
		input logic signed [31:0] v);
		eq_item_t it;
		it = noise_item(k);
		it.band = 5'(b);
		it.tap = 4'(t);
		it.coeff = v;
		pending_items.push_back(it);
	endtask

	task automatic push_gain(input int b, input logic signed [7:0] g);
		eq_item_t it;
		it = noise_item(KIND_GAIN);
		it.band = 5'(b);
		it.raw_gain = g;
		pending_items.push_back(it);
	endtask

	// Moderate coefficient: mostly well-behaved, sometimes any 32-bit value.
	function automatic logic signed [31:0] pick_coeff(input int span);
		logic signed [31:0] v;
		if ($urandom_range(9) == 0) return 32'($urandom);
		v = 32'($urandom_range(span));
		return $urandom_range(1) ? -v : v;
	endfunction

	// Random traffic; ignored loads are sent but not counted.
	task automatic push_random(input int count);
		int done;
		int sel;
		eq_item_t it;
		done = 0;
		while (done < count) begin
			sel = $urandom_range(99);
			if (sel < 55) begin
				it = noise_item(KIND_SAMPLE);
				done++;
			end else if (sel < 70) begin
				it = noise_item(KIND_LOAD_FF);
				it.coeff = pick_coeff(1 << 27);
				done++;
			end else if (sel < 80) begin
				it = noise_item(KIND_LOAD_FB);
				it.coeff = pick_coeff(1 << 25);
				done++;
			end else if (sel < 95) begin
				it = noise_item(KIND_GAIN);
				done++;
			end else begin
				it = noise_item($urandom_range(1) ? KIND_LOAD_FF : KIND_LOAD_FB);
				it.tap = 4'($urandom_range(15, NTAPS));
			end
			pending_items.push_back(it);
		end
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || item_ch.valid || expected_outputs.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_ACTIVE_BANDS: cfg_bands = v[5:0];
			REG_GAIN_DECAY:   cfg_decay = v[15:0];
			default:          cfg_scale = v[15:0];
		endcase
	endtask

	task automatic set_regs(input int b, input int d, input int s);
		reg_write(REG_ACTIVE_BANDS, 32'(b));
		reg_write(REG_GAIN_DECAY, 32'(d));
		reg_write(REG_OUTPUT_SCALE, 32'(s));
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin snd_idle = 29; rcv_idle = 65; end
			1: begin snd_idle = 65; rcv_idle = 29; end
			default: begin snd_idle = 0; rcv_idle = 0; end
		endcase
	endtask

	// Reset, setup, directed part, then random phases over several settings.
	initial begin
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		item_ch.valid = 1'b0; item_ch.kind = '0; item_ch.sample = '0; item_ch.band = '0;
		item_ch.tap = '0; item_ch.coeff_value = '0; item_ch.raw_gain = '0;
		res_ch.ready = 1'b0;
		arst_n = 1'b0;
		errors = 0; stall_cycles = 0; samples_checked = 0; loads_seen = 0; gains_seen = 0;
		cfg_bands = ACTIVE_BANDS_RST; cfg_decay = GAIN_DECAY_RST; cfg_scale = OUTPUT_SCALE_RST;
		foreach (gain_model[i]) gain_model[i] = '0;
		foreach (x_hist[i]) x_hist[i] = '0;
		foreach (y_hist[i, j]) y_hist[i][j] = '0;
		foreach (ff_taps[i, j]) begin ff_taps[i][j] = '0; fb_taps[i][j] = '0; end
		set_idling(0);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Write every coefficient a sample can read, and give each band a gain.
		for (int b = 0; b < NBANDS; b++) begin
			for (int t = 0; t < NTAPS; t++) begin
				push_load(KIND_LOAD_FF, b, t, pick_coeff(1 << 27));
				if (t > 0) push_load(KIND_LOAD_FB, b, t, pick_coeff(1 << 25));
			end
			push_gain(b, 8'($urandom_range(127, 20)));
		end

		// Directed: sample extremes at the reset settings.
		push_sample(16'sh7FFF);
		push_sample(-16'sh8000);
		push_sample(16'sd0);
		push_sample(-16'sd1);
		// Gain extremes, including a negative gain and the decay floor.
		push_gain(3, 8'sh7F);
		push_gain(4, -8'sh80);
		push_gain(5, 8'sd0);
		push_gain(6, -8'sd1);
		push_gain(7, 8'sd1);
		push_gain(3, 8'sd0);
		// Feedback tap zero is stored but unused; out-of-range taps are dropped.
		push_load(KIND_LOAD_FB, 0, 0, 32'sh7FFFFFFF);
		push_load(KIND_LOAD_FF, 1, 5, 32'sh7FFFFFFF);
		push_load(KIND_LOAD_FB, 1, 15, -32'sh80000000);
		// Extreme taps with full gain drive the sum into saturation.
		push_load(KIND_LOAD_FF, 0, 0, 32'sh7FFFFFFF);
		push_load(KIND_LOAD_FF, 2, 0, -32'sh80000000);
		push_gain(0, 8'sh7F);
		push_sample(16'sh7FFF);
		push_sample(-16'sh8000);
		push_load(KIND_LOAD_FF, 0, 0, 32'sh01000000);
		push_load(KIND_LOAD_FF, 2, 0, -32'sh01000000);
		push_sample(16'sh1234);
		wait_idle();

		// Random phases: extremes of every register, with the idling modes in turn.
		set_regs(32, 65535, 65535); set_idling(0); push_random(60); wait_idle();
		set_regs(1, 0, 0);          set_idling(0); push_random(55); wait_idle();
		set_regs(0, 52429, 39322);  set_idling(1); push_random(50); wait_idle();
		set_regs(63, 30000, 65535); set_idling(1); push_random(60); wait_idle();
		set_regs(5, 65535, 20000);  set_idling(2); push_random(60); wait_idle();
		set_regs($urandom_range(31, 2), $urandom_range(65535), $urandom_range(65535));
		set_idling(2); push_random(65); wait_idle();

		$display("Checked %0d output samples over %0d coefficient loads and %0d gain updates,",
			samples_checked, loads_seen, gains_seen);
		$display("across seven register settings and three idling patterns.");
		if (errors == 0 && expected_outputs.size() == 0) begin
			$display("gain_scaled_iir_band_equalizer: match");
		end else begin
			$display("gain_scaled_iir_band_equalizer: mismatch");
		end
		$finish;
	end

endmodule
